### src/plp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the pkt-line request parser.
// No dependencies; the core, the result register and the top level import this package.
package plp_pkg;

    localparam int OID_MAX_DIGITS = 64;
    localparam int SHA1_DIGITS    = 40;
    localparam int DIG_W          = $clog2(OID_MAX_DIGITS + 1);
    localparam int OID_WORDS      = 4;

    localparam logic [DIG_W-1:0] DIGITS_SHA1   = DIG_W'(SHA1_DIGITS);
    localparam logic [DIG_W-1:0] DIGITS_SHA256 = DIG_W'(OID_MAX_DIGITS);

    // packet kinds
    localparam logic [1:0] KIND_FLUSH = 2'd0;
    localparam logic [1:0] KIND_WANT  = 2'd1;
    localparam logic [1:0] KIND_HAVE  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // result status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_HEX    = 4'd1;
    localparam logic [3:0] ST_SHORT_LEN  = 4'd2;
    localparam logic [3:0] ST_BAD_TYPE   = 4'd3;
    localparam logic [3:0] ST_BAD_OID    = 4'd4;
    localparam logic [3:0] ST_NO_SPACE   = 4'd5;
    localparam logic [3:0] ST_CAPS_OPEN  = 4'd6;
    localparam logic [3:0] ST_NO_NEWLINE = 4'd7;
    localparam logic [3:0] ST_TRAILING   = 4'd8;

    localparam logic [7:0] CH_NL = 8'h0a;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_W  = 8'h77;
    localparam logic [7:0] CH_H  = 8'h68;
    localparam logic [7:0] CH_D  = 8'h64;

    localparam logic [39:0] TXT_WANT = "want ";
    localparam logic [39:0] TXT_HAVE = "have ";
    localparam logic [39:0] TXT_DONE = {"done", CH_NL};

    typedef enum logic [2:0] {
        PH_LEN,
        PH_TYPE,
        PH_OID,
        PH_AFTER,
        PH_CAPS,
        PH_END
    } t_phase;

    typedef struct packed {
        logic [1:0]                  pkt_kind;
        logic [3:0]                  status;
        logic [OID_WORDS-1:0][63:0]  oid;
        logic [15:0]                 caps_offset;
        logic [15:0]                 caps_len;
        logic [15:0]                 pkt_len;
    } t_result;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // expected character at position p of the type text of a kind
    function automatic logic [7:0] type_char(input logic [1:0] kind, input logic [2:0] p);
        logic [39:0] txt;
        logic [7:0]  c;
        txt = 40'd0;
        unique case (kind)
            KIND_WANT: txt = TXT_WANT;
            KIND_HAVE: txt = TXT_HAVE;
            KIND_DONE: txt = TXT_DONE;
            default:   txt = 40'd0;
        endcase
        unique case (p)
            3'd0:    c = txt[39:32];
            3'd1:    c = txt[31:24];
            3'd2:    c = txt[23:16];
            3'd3:    c = txt[15:8];
            3'd4:    c = txt[7:0];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

### src/plp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: incoming stream bytes and parse results.
// No dependencies; the result interface spells out the oid as four separate 64-bit words.
interface plp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface plp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pkt_kind;
    logic [3:0]  status;
    logic [63:0] oid_word0;
    logic [63:0] oid_word1;
    logic [63:0] oid_word2;
    logic [63:0] oid_word3;
    logic [15:0] caps_offset;
    logic [15:0] caps_len;
    logic [15:0] pkt_len;

    modport source (output valid, output pkt_kind, output status, output oid_word0,
                    output oid_word1, output oid_word2, output oid_word3,
                    output caps_offset, output caps_len, output pkt_len, input ready);
    modport sink   (input valid, input pkt_kind, input status, input oid_word0,
                    input oid_word1, input oid_word2, input oid_word3,
                    input caps_offset, input caps_len, input pkt_len, output ready);
endinterface

### src/plp_in_reg.sv
`timescale 1ns / 1ps
// Input register: captures one stream word and holds it until the parser takes it.
// Depends on plp_byte_if.
module plp_in_reg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plp_byte_if.sink     i_rx,
    input  logic         i_take,
    output logic         o_valid,
    output logic [7:0]   o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign i_rx.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end
endmodule

### src/plp_core.sv
`timescale 1ns / 1ps
// Parser state and per-word next-state logic; raises a result on packet end or error.
// Depends on plp_pkg.
module plp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_res_valid,
    output plp_pkg::t_result  o_res
);
    import plp_pkg::*;

    logic                       r_oid_format;
    t_phase                     r_phase,     n_phase;
    logic [15:0]                r_len,       n_len;
    logic [15:0]                r_idx,       n_idx;
    logic [OID_WORDS-1:0][63:0] r_oid,       n_oid;
    logic                       r_caps_read, n_caps_read;
    logic                       r_halted,    n_halted;
    logic [15:0]                r_caps_start, n_caps_start;
    logic [15:0]                r_caps_count, n_caps_count;
    logic [1:0]                 r_kind,      n_kind;

    assign o_take = i_valid && i_out_free;

    always_comb begin
        logic [4:0]       hx;
        logic [DIG_W-1:0] digits;
        logic [15:0]      d;
        logic [15:0]      p;
        logic [15:0]      idx1;
        t_phase           ph;
        logic [3:0]       st;
        logic             do_ok;
        logic             is_flush;
        logic             clear;

        hx       = hex_decode(i_byte);
        digits   = r_oid_format ? DIGITS_SHA256 : DIGITS_SHA1;
        d        = r_idx - 16'd9;
        p        = r_idx - 16'd4;
        idx1     = r_idx + 16'd1;
        ph       = r_phase;
        st       = ST_OK;
        do_ok    = 1'b0;
        is_flush = 1'b0;
        clear    = 1'b0;

        n_phase      = r_phase;
        n_len        = r_len;
        n_idx        = r_idx;
        n_oid        = r_oid;
        n_caps_read  = r_caps_read;
        n_halted     = r_halted;
        n_caps_start = r_caps_start;
        n_caps_count = r_caps_count;
        n_kind       = r_kind;

        if (o_take && !r_halted) begin
            if (r_phase == PH_LEN) begin
                if (!hx[4]) begin
                    st = ST_BAD_HEX;
                end else begin
                    n_len = {r_len[11:0], hx[3:0]};
                    n_idx = idx1;
                    if (r_idx[1:0] == 2'd3) begin
                        priority if (n_len == 16'd0) begin
                            do_ok    = 1'b1;
                            is_flush = 1'b1;
                        end else if (n_len < 16'd4) begin
                            st = ST_SHORT_LEN;
                        end else if (n_len == 16'd4) begin
                            st = ST_BAD_TYPE;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                end
            end else begin
                // id already complete for the current digit count
                if (ph == PH_OID && d >= 16'(digits)) begin
                    ph = PH_AFTER;
                end
                unique case (ph)
                    PH_TYPE: begin
                        if (p == 16'd0) begin
                            priority if (i_byte == CH_W) begin
                                n_kind = KIND_WANT;
                            end else if (i_byte == CH_H) begin
                                n_kind = KIND_HAVE;
                            end else if (i_byte == CH_D) begin
                                n_kind = KIND_DONE;
                            end else begin
                                st = ST_BAD_TYPE;
                            end
                        end else if (p > 16'd4 || r_kind == KIND_FLUSH
                                     || type_char(r_kind, p[2:0]) != i_byte) begin
                            st = ST_BAD_TYPE;
                        end
                        if (st == ST_OK && p == 16'd4) begin
                            ph = (n_kind == KIND_DONE) ? PH_END : PH_OID;
                        end
                    end
                    PH_OID: begin
                        if (!hx[4]) begin
                            st = ST_BAD_OID;
                        end else begin
                            n_oid[d[5:4]][6'd60 - {d[3:0], 2'b00} +: 4] =
                                r_oid[d[5:4]][6'd60 - {d[3:0], 2'b00} +: 4] | hx[3:0];
                            if (idx1 - 16'd9 >= 16'(digits)) begin
                                ph = PH_AFTER;
                            end
                        end
                    end
                    PH_AFTER: begin
                        if (r_kind == KIND_WANT && !r_caps_read
                            && (r_len - r_idx) > 16'd1) begin
                            if (i_byte != CH_SP) begin
                                st = ST_NO_SPACE;
                            end else begin
                                n_caps_start = idx1;
                                n_caps_count = 16'd0;
                                ph = PH_CAPS;
                            end
                        end else if (i_byte != CH_NL) begin
                            st = ST_NO_NEWLINE;
                        end else begin
                            ph = PH_END;
                        end
                    end
                    PH_CAPS: begin
                        if (i_byte == CH_NL) begin
                            ph = PH_END;
                        end else begin
                            n_caps_count = r_caps_count + 16'd1;
                        end
                    end
                    default: begin
                        st = (r_kind == KIND_DONE) ? ST_BAD_TYPE : ST_TRAILING;
                    end
                endcase

                if (st == ST_OK) begin
                    n_idx   = idx1;
                    n_phase = ph;
                    // last word of the packet: close it out
                    if (!(idx1 < r_len)) begin
                        unique case (ph)
                            PH_END:  do_ok = 1'b1;
                            PH_TYPE: st = ST_BAD_TYPE;
                            PH_OID:  st = ST_BAD_OID;
                            PH_CAPS: st = ST_CAPS_OPEN;
                            default: st = ST_NO_NEWLINE;
                        endcase
                    end
                end
            end
        end

        o_res_valid = do_ok || (st != ST_OK);
        o_res       = '0;
        if (do_ok) begin
            o_res.pkt_kind = is_flush ? KIND_FLUSH : n_kind;
            o_res.status   = ST_OK;
            o_res.pkt_len  = is_flush ? 16'd4 : n_len;
            if (!is_flush && n_kind != KIND_DONE) begin
                o_res.oid = n_oid;
            end
            if (!is_flush && n_kind == KIND_WANT && n_caps_start != 16'd0) begin
                o_res.caps_offset = n_caps_start;
                o_res.caps_len    = n_caps_count;
            end
            if (!is_flush && n_kind == KIND_WANT) begin
                n_caps_read = 1'b1;
            end
            clear = 1'b1;
        end else if (st != ST_OK) begin
            o_res.pkt_kind = (st <= ST_BAD_TYPE) ? KIND_FLUSH : n_kind;
            o_res.status   = st;
            o_res.pkt_len  = (st == ST_BAD_HEX) ? 16'd0 : n_len;
            n_halted       = 1'b1;
        end

        if (clear) begin
            n_phase      = PH_LEN;
            n_len        = 16'd0;
            n_idx        = 16'd0;
            n_oid        = '0;
            n_caps_start = 16'd0;
            n_caps_count = 16'd0;
            n_kind       = KIND_FLUSH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oid_format <= 1'b0;
            r_phase      <= PH_LEN;
            r_len        <= 16'd0;
            r_idx        <= 16'd0;
            r_oid        <= '0;
            r_caps_read  <= 1'b0;
            r_halted     <= 1'b0;
            r_caps_start <= 16'd0;
            r_caps_count <= 16'd0;
            r_kind       <= KIND_FLUSH;
        end else begin
            if (i_cfg_we) begin
                r_oid_format <= i_cfg_wdata;
            end
            r_phase      <= n_phase;
            r_len        <= n_len;
            r_idx        <= n_idx;
            r_oid        <= n_oid;
            r_caps_read  <= n_caps_read;
            r_halted     <= n_halted;
            r_caps_start <= n_caps_start;
            r_caps_count <= n_caps_count;
            r_kind       <= n_kind;
        end
    end
endmodule

### src/plp_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one parse result until the downstream side takes it.
// Depends on plp_pkg and plp_result_if.
module plp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  plp_pkg::t_result  i_res,
    output logic              o_free,
    plp_result_if.source      o_res
);
    import plp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.pkt_kind    = r_res.pkt_kind;
    assign o_res.status      = r_res.status;
    assign o_res.oid_word0   = r_res.oid[0];
    assign o_res.oid_word1   = r_res.oid[1];
    assign o_res.oid_word2   = r_res.oid[2];
    assign o_res.oid_word3   = r_res.oid[3];
    assign o_res.caps_offset = r_res.caps_offset;
    assign o_res.caps_len    = r_res.caps_len;
    assign o_res.pkt_len     = r_res.pkt_len;
endmodule

### src/pkt_line_request_parser_unit.sv
`timescale 1ns / 1ps
// pkt-line request parser, top level: input register, parser core, result register.
// An accepted word is held in the input register, parsed combinationally by the core, and its result is registered.
// Throughput: one word per cycle while the result register is free; the parser state loop updates once per word.
// Stall: the input register holds while the result register is full and not taken.
// Reset (synchronous, active low): clears parser state, halt flag and oid format to SHA-1.
module pkt_line_request_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    plp_byte_if.sink      i_rx,
    plp_result_if.source  o_res
);
    import plp_pkg::*;

    logic       take;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       res_valid;
    t_result    res;

    plp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    plp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (byte_valid),
        .i_byte      (byte_data),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    plp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );
endmodule
